/* hw/rtl/ich_pkg.sv */
// shared types and constants for the innovation covariance block
package ich_pkg;

  localparam int MEAS_MAX   = 4;
  localparam int STATE_DIM  = 13;
  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;

  localparam int MI_W = (MEAS_MAX > 1) ? $clog2(MEAS_MAX) : 1;
  localparam int SI_W = (STATE_DIM > 1) ? $clog2(STATE_DIM) : 1;
  localparam int HA_W = (MEAS_MAX * STATE_DIM > 1) ? $clog2(MEAS_MAX * STATE_DIM) : 1;
  localparam int PA_W = (STATE_DIM * STATE_DIM > 1) ? $clog2(STATE_DIM * STATE_DIM) : 1;
  localparam int SA_W = (MEAS_MAX * MEAS_MAX > 1) ? $clog2(MEAS_MAX * MEAS_MAX) : 1;
  localparam int DA_W = (HA_W > SA_W) ? HA_W : SA_W;

  localparam logic [DATA_WIDTH-1:0] FILLER = DATA_WIDTH'(64'd1023 << FRAC_BITS);

  typedef enum logic [1:0] {
    CMD_LOAD_H  = 2'd0,
    CMD_LOAD_P  = 2'd1,
    CMD_LOAD_R  = 2'd2,
    CMD_COMPUTE = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e         command;
    logic [3:0]   row;
    logic [3:0]   col;
    logic [31:0]  value;
    logic [3:0]   valid_count;
    logic [11:0]  particle;
  } in_t;

  typedef struct packed {
    logic [11:0]           out_particle;
    logic [2:0]            out_row;
    logic [2:0]            out_col;
    logic [DATA_WIDTH-1:0] entry;
    logic                  last;
  } out_t;

  typedef struct packed {
    logic                  valid;
    logic                  first;
    logic                  last;
    logic                  fill;
    logic                  diag;
    logic                  phase_s;
    logic [DA_W-1:0]       addr;
    logic [DATA_WIDTH-1:0] r_val;
  } mac_tag_t;

  typedef struct packed {
    logic                  en;
    logic                  phase_s;
    logic [DA_W-1:0]       addr;
    logic [DATA_WIDTH-1:0] data;
  } mac_wr_t;

endpackage

/* hw/rtl/ich_mac.sv */
// multiply-accumulate datapath with result write-back
module ich_mac (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  ich_pkg::mac_tag_t               tag_i,
  input  logic [ich_pkg::DATA_WIDTH-1:0]  a_i,
  input  logic [ich_pkg::DATA_WIDTH-1:0]  b_i,
  output ich_pkg::mac_wr_t                wr_o
);

  logic signed [2*ich_pkg::DATA_WIDTH-1:0] full;
  logic [ich_pkg::DATA_WIDTH-1:0]          prod_d, prod_q;
  logic [ich_pkg::DATA_WIDTH-1:0]          acc_d, acc_q;
  logic [ich_pkg::DATA_WIDTH-1:0]          base;
  ich_pkg::mac_tag_t                       tag_q;

  assign full   = $signed(a_i) * $signed(b_i);
  assign prod_d = full[ich_pkg::FRAC_BITS +: ich_pkg::DATA_WIDTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else begin
      tag_q <= tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
  end

  assign acc_d = (tag_q.first ? '0 : acc_q) + prod_q;
  assign base  = tag_q.fill ? ich_pkg::FILLER : acc_d;

  always_comb begin
    wr_o.en      = tag_q.valid && tag_q.last;
    wr_o.phase_s = tag_q.phase_s;
    wr_o.addr    = tag_q.addr;
    wr_o.data    = base + (tag_q.diag ? tag_q.r_val : '0);
  end

endmodule

/* hw/rtl/innovation_covariance_hph_top.sv */
// top level of the innovation covariance block
// A load transfer (H, P or R element) leaves busy_o low.
// A compute transfer runs H*P through one multiply-accumulate unit, one term
// per cycle, then (H*P)*H', and then emits MEAS_MAX*MEAS_MAX results on
// consecutive cycles. busy_o is high from the cycle after a compute transfer
// until the final result has been strobed; result_valid_o marks each result
// for one cycle and the receiver cannot stall.
module innovation_covariance_hph_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  ich_pkg::in_t  item_i,
  output logic          busy_o,
  output logic          result_valid_o,
  output ich_pkg::out_t result_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_OUT,
    ST_FLUSH
  } state_e;

  localparam int DW = ich_pkg::DATA_WIDTH;

  state_e                  state_q;
  logic                    phase_q;
  logic [ich_pkg::MI_W-1:0] i_q;
  logic [ich_pkg::SI_W-1:0] k_q, j_q;
  logic [1:0]              drain_q;
  logic [3:0]              cnt_q;
  logic [11:0]             part_q;
  logic [ich_pkg::MI_W-1:0] oi_q, oj_q;
  logic                    ov_q, olast_q;
  logic [ich_pkg::MI_W-1:0] orow_q, ocol_q;

  logic [DW-1:0] h_mem  [ich_pkg::MEAS_MAX*ich_pkg::STATE_DIM];
  logic [DW-1:0] p_mem  [ich_pkg::STATE_DIM*ich_pkg::STATE_DIM];
  logic [DW-1:0] hp_mem [ich_pkg::MEAS_MAX*ich_pkg::STATE_DIM];
  logic [DW-1:0] s_mem  [ich_pkg::MEAS_MAX*ich_pkg::MEAS_MAX];
  logic [DW-1:0] r_q    [ich_pkg::MEAS_MAX];

  logic [DW-1:0] h_rd_q, p_rd_q, hp_rd_q, s_a_q, s_b_q;
  logic          accept, issue;
  logic [ich_pkg::HA_W-1:0] h_ra, h_wa, hp_ra;
  logic [ich_pkg::PA_W-1:0] p_ra, p_wa;
  logic [ich_pkg::SA_W-1:0] s_ra, s_rb;
  logic          k_end, i_end, j_end, o_end;
  logic          fill;
  ich_pkg::mac_tag_t tag_d, tag_q;
  ich_pkg::mac_wr_t  wr;
  logic [DW:0]   sum;

  assign accept = start_i && (state_q == ST_IDLE);
  assign busy_o = (state_q != ST_IDLE);
  assign issue  = (state_q == ST_MAC);

  assign h_wa = ich_pkg::HA_W'(32'(item_i.row) * ich_pkg::STATE_DIM + 32'(item_i.col));
  assign p_wa = ich_pkg::PA_W'(32'(item_i.row) * ich_pkg::STATE_DIM + 32'(item_i.col));

  assign h_ra  = phase_q ? ich_pkg::HA_W'(32'(k_q) * ich_pkg::STATE_DIM + 32'(j_q))
                         : ich_pkg::HA_W'(32'(i_q) * ich_pkg::STATE_DIM + 32'(j_q));
  assign p_ra  = ich_pkg::PA_W'(32'(j_q) * ich_pkg::STATE_DIM + 32'(k_q));
  assign hp_ra = ich_pkg::HA_W'(32'(i_q) * ich_pkg::STATE_DIM + 32'(j_q));
  assign s_ra  = ich_pkg::SA_W'(32'(oi_q) * ich_pkg::MEAS_MAX + 32'(oj_q));
  assign s_rb  = ich_pkg::SA_W'(32'(oj_q) * ich_pkg::MEAS_MAX + 32'(oi_q));

  assign j_end = (32'(j_q) == ich_pkg::STATE_DIM - 1);
  assign k_end = phase_q ? (32'(k_q) == ich_pkg::MEAS_MAX - 1)
                         : (32'(k_q) == ich_pkg::STATE_DIM - 1);
  assign i_end = (32'(i_q) == ich_pkg::MEAS_MAX - 1);
  assign o_end = (32'(oi_q) == ich_pkg::MEAS_MAX - 1) && (32'(oj_q) == ich_pkg::MEAS_MAX - 1);
  assign fill  = (32'(i_q) >= 32'(cnt_q)) || (phase_q && (32'(k_q) >= 32'(cnt_q)));

  // h, p and r memories
  always_ff @(posedge clk_i) begin
    if (accept && item_i.command == ich_pkg::CMD_LOAD_H &&
        32'(item_i.row) < ich_pkg::MEAS_MAX && 32'(item_i.col) < ich_pkg::STATE_DIM) begin
      h_mem[h_wa] <= item_i.value[DW-1:0];
    end
    h_rd_q <= h_mem[h_ra];
  end

  always_ff @(posedge clk_i) begin
    if (accept && item_i.command == ich_pkg::CMD_LOAD_P &&
        32'(item_i.row) < ich_pkg::STATE_DIM && 32'(item_i.col) < ich_pkg::STATE_DIM) begin
      p_mem[p_wa] <= item_i.value[DW-1:0];
    end
    p_rd_q <= p_mem[p_ra];
  end

  always_ff @(posedge clk_i) begin
    if (accept && item_i.command == ich_pkg::CMD_LOAD_R &&
        32'(item_i.row) < ich_pkg::MEAS_MAX) begin
      r_q[item_i.row[ich_pkg::MI_W-1:0]] <= item_i.value[DW-1:0];
    end
  end

  // scratch memories
  always_ff @(posedge clk_i) begin
    if (wr.en && !wr.phase_s) begin
      hp_mem[wr.addr[ich_pkg::HA_W-1:0]] <= wr.data;
    end
    hp_rd_q <= hp_mem[hp_ra];
  end

  always_ff @(posedge clk_i) begin
    if (wr.en && wr.phase_s) begin
      s_mem[wr.addr[ich_pkg::SA_W-1:0]] <= wr.data;
    end
    s_a_q <= s_mem[s_ra];
    s_b_q <= s_mem[s_rb];
  end

  always_comb begin
    tag_d.valid   = issue;
    tag_d.first   = (j_q == '0);
    tag_d.last    = j_end;
    tag_d.fill    = fill;
    tag_d.diag    = phase_q && (32'(k_q) == 32'(i_q));
    tag_d.phase_s = phase_q;
    tag_d.addr    = phase_q ? ich_pkg::DA_W'(32'(i_q) * ich_pkg::MEAS_MAX + 32'(k_q))
                            : ich_pkg::DA_W'(32'(i_q) * ich_pkg::STATE_DIM + 32'(k_q));
    tag_d.r_val   = r_q[i_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else begin
      tag_q <= tag_d;
    end
  end

  ich_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tag_i  (tag_q),
    .a_i    (phase_q ? hp_rd_q : h_rd_q),
    .b_i    (phase_q ? h_rd_q : p_rd_q),
    .wr_o   (wr)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= 1'b0;
      i_q     <= '0;
      k_q     <= '0;
      j_q     <= '0;
      drain_q <= '0;
      cnt_q   <= '0;
      part_q  <= '0;
      oi_q    <= '0;
      oj_q    <= '0;
      ov_q    <= 1'b0;
      olast_q <= 1'b0;
      orow_q  <= '0;
      ocol_q  <= '0;
    end else begin
      ov_q <= (state_q == ST_OUT);
      unique case (state_q)
        ST_IDLE: begin
          if (accept && item_i.command == ich_pkg::CMD_COMPUTE) begin
            cnt_q   <= (32'(item_i.valid_count) > ich_pkg::MEAS_MAX) ?
                       4'(ich_pkg::MEAS_MAX) : item_i.valid_count;
            part_q  <= item_i.particle;
            phase_q <= 1'b0;
            i_q     <= '0;
            k_q     <= '0;
            j_q     <= '0;
            state_q <= ST_MAC;
          end
        end
        ST_MAC: begin
          if (!j_end) begin
            j_q <= j_q + 1'b1;
          end else begin
            j_q <= '0;
            if (!k_end) begin
              k_q <= k_q + 1'b1;
            end else begin
              k_q <= '0;
              if (!i_end) begin
                i_q <= i_q + 1'b1;
              end else begin
                i_q     <= '0;
                drain_q <= '0;
                state_q <= ST_DRAIN;
              end
            end
          end
        end
        ST_DRAIN: begin
          drain_q <= drain_q + 1'b1;
          if (drain_q == 2'd2) begin
            if (!phase_q) begin
              phase_q <= 1'b1;
              state_q <= ST_MAC;
            end else begin
              oi_q    <= '0;
              oj_q    <= '0;
              state_q <= ST_OUT;
            end
          end
        end
        ST_OUT: begin
          olast_q <= o_end;
          orow_q  <= oi_q;
          ocol_q  <= oj_q;
          if (32'(oj_q) == ich_pkg::MEAS_MAX - 1) begin
            oj_q <= '0;
            oi_q <= oi_q + 1'b1;
          end else begin
            oj_q <= oj_q + 1'b1;
          end
          if (o_end) begin
            state_q <= ST_FLUSH;
          end
        end
        ST_FLUSH: begin
          state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign sum = {s_a_q[DW-1], s_a_q} + {s_b_q[DW-1], s_b_q};

  assign result_valid_o        = ov_q;
  assign result_o.out_particle = part_q;
  assign result_o.out_row      = 3'(orow_q);
  assign result_o.out_col      = 3'(ocol_q);
  assign result_o.entry        = sum[DW:1];
  assign result_o.last         = olast_q;

endmodule

/* tb/sv/innovation_covariance_checker.sv */
// checker that predicts and compares the covariance results of the block
`timescale 1ns / 1ps
module innovation_covariance_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          busy_i,
  input  ich_pkg::in_t  item_i,
  input  logic          result_valid_i,
  input  ich_pkg::out_t result_i,
  output int            fails_o,
  output int            pending_o
);
  import ich_pkg::*;

  logic [DATA_WIDTH-1:0] h_mem [MEAS_MAX*STATE_DIM];
  logic [DATA_WIDTH-1:0] p_mem [STATE_DIM*STATE_DIM];
  logic [DATA_WIDTH-1:0] r_mem [MEAS_MAX];
  out_t                  entry_q [$];

  function automatic logic [DATA_WIDTH-1:0] fx_mul(logic [DATA_WIDTH-1:0] a,
                                                   logic [DATA_WIDTH-1:0] b);
    logic signed [63:0] sa;
    logic signed [63:0] sb;
    logic signed [63:0] pr;
    sa = $signed(a);
    sb = $signed(b);
    pr = sa * sb;
    pr = pr >>> FRAC_BITS;
    return pr[DATA_WIDTH-1:0];
  endfunction

  function automatic logic [DATA_WIDTH-1:0] fx_mean(logic [DATA_WIDTH-1:0] a,
                                                    logic [DATA_WIDTH-1:0] b);
    logic signed [DATA_WIDTH:0] sum;
    sum = $signed({a[DATA_WIDTH-1], a}) + $signed({b[DATA_WIDTH-1], b});
    sum = sum >>> 1;
    return sum[DATA_WIDTH-1:0];
  endfunction

  task automatic predict_covariance(in_t it);
    logic [DATA_WIDTH-1:0] hp [MEAS_MAX][STATE_DIM];
    logic [DATA_WIDTH-1:0] s [MEAS_MAX][MEAS_MAX];
    logic [DATA_WIDTH-1:0] acc;
    int   cnt;
    out_t e;
    cnt = (it.valid_count > MEAS_MAX) ? MEAS_MAX : int'(it.valid_count);
    for (int i = 0; i < MEAS_MAX; i++) begin
      for (int k = 0; k < STATE_DIM; k++) begin
        acc = '0;
        if (i < cnt) begin
          for (int j = 0; j < STATE_DIM; j++)
            acc = acc + fx_mul(h_mem[i*STATE_DIM+j], p_mem[j*STATE_DIM+k]);
        end else begin
          acc = FILLER;
        end
        hp[i][k] = acc;
      end
    end
    for (int i = 0; i < MEAS_MAX; i++) begin
      for (int k = 0; k < MEAS_MAX; k++) begin
        acc = '0;
        if (i < cnt && k < cnt) begin
          for (int j = 0; j < STATE_DIM; j++)
            acc = acc + fx_mul(hp[i][j], h_mem[k*STATE_DIM+j]);
        end else begin
          acc = FILLER;
        end
        s[i][k] = acc;
      end
      s[i][i] = s[i][i] + r_mem[i];
    end
    for (int i = 0; i < MEAS_MAX; i++) begin
      for (int j = 0; j < MEAS_MAX; j++) begin
        e.out_particle = it.particle;
        e.out_row      = 3'(i);
        e.out_col      = 3'(j);
        e.entry        = fx_mean(s[i][j], s[j][i]);
        e.last         = (i == MEAS_MAX-1) && (j == MEAS_MAX-1);
        entry_q.push_back(e);
      end
    end
  endtask

  task automatic report_mismatch(out_t want, out_t got, bit none);
    fails_o = fails_o + 1;
    if (fails_o <= 10) begin
      if (none)
        $display("unexpected result: particle %0d row %0d col %0d entry %h last %0d",
                 got.out_particle, got.out_row, got.out_col, got.entry, got.last);
      else
        $display("mismatch: expected p%0d r%0d c%0d %h l%0d, got p%0d r%0d c%0d %h l%0d",
                 want.out_particle, want.out_row, want.out_col, want.entry, want.last,
                 got.out_particle, got.out_row, got.out_col, got.entry, got.last);
    end
  endtask

  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni) begin
      if (result_valid_i) begin
        if (entry_q.size() == 0) begin
          report_mismatch(result_i, result_i, 1'b1);
        end else begin
          want = entry_q.pop_front();
          if (want !== result_i) report_mismatch(want, result_i, 1'b0);
        end
      end
      if (start_i && !busy_i) begin
        case (item_i.command)
          CMD_LOAD_H: begin
            if (item_i.row < MEAS_MAX && item_i.col < STATE_DIM)
              h_mem[item_i.row*STATE_DIM+item_i.col] = item_i.value;
          end
          CMD_LOAD_P: begin
            if (item_i.row < STATE_DIM && item_i.col < STATE_DIM)
              p_mem[item_i.row*STATE_DIM+item_i.col] = item_i.value;
          end
          CMD_LOAD_R: begin
            if (item_i.row < MEAS_MAX) r_mem[item_i.row] = item_i.value;
          end
          default: predict_covariance(item_i);
        endcase
      end
      pending_o = entry_q.size();
    end
  end

endmodule

/* tb/sv/tb_innovation_covariance_hph_top.sv */
// testbench top: stimulus, clock, reset and verdict for the covariance block
`timescale 1ns / 1ps
module tb_innovation_covariance_hph_top;
  import ich_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;

  logic clk_i;
  logic rst_ni;
  logic start_i;
  in_t  item_i;
  logic busy_o;
  logic result_valid_o;
  out_t result_o;
  int   fails;
  int   pending;
  int   cycles;

  innovation_covariance_hph_top u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .item_i         (item_i),
    .busy_o         (busy_o),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  innovation_covariance_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_i         (busy_o),
    .item_i         (item_i),
    .result_valid_i (result_valid_o),
    .result_i       (result_o),
    .fails_o        (fails),
    .pending_o      (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles = cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
        $display("tb_innovation_covariance_hph_top NOT OK");
        $finish;
      end
    end
  end

  // holds the item until the block takes the transfer
  task automatic send(cmd_e cmd, int row, int col, logic [31:0] value, int cnt, int part);
    logic b;
    in_t  it;
    it.command     = cmd;
    it.row         = 4'(row);
    it.col         = 4'(col);
    it.value       = value;
    it.valid_count = 4'(cnt);
    it.particle    = 12'(part);
    item_i  <= it;
    start_i <= 1'b1;
    forever begin
      @(negedge clk_i);
      b = busy_o;
      @(posedge clk_i);
      if (!b) break;
    end
  endtask

  task automatic idle(int n);
    start_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic drain();
    start_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_value();
    int m;
    m = $urandom_range(0, 9);
    if (m < 5) return 32'($urandom_range(0, 32'h3ffff)) - 32'h20000;
    if (m < 8) return $urandom;
    if (m == 8) return 32'h7fffffff;
    return 32'h80000000;
  endfunction

  function automatic int rand_count();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 15);
    return $urandom_range(0, MEAS_MAX);
  endfunction

  initial begin
    int r;
    rst_ni  = 1'b0;
    start_i = 1'b0;
    item_i  = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // every element loaded once so nothing unwritten is read
    for (int i = 0; i < MEAS_MAX; i++)
      for (int j = 0; j < STATE_DIM; j++) send(CMD_LOAD_H, i, j, rand_value(), 0, 0);
    for (int i = 0; i < STATE_DIM; i++)
      for (int j = 0; j < STATE_DIM; j++) send(CMD_LOAD_P, i, j, rand_value(), 0, 0);
    for (int i = 0; i < MEAS_MAX; i++) send(CMD_LOAD_R, i, 0, rand_value(), 0, 0);

    // directed corners
    send(CMD_COMPUTE, 0, 0, 32'h0, 0, 0);
    send(CMD_COMPUTE, 15, 15, 32'hffffffff, 15, 4095);
    send(CMD_LOAD_H, 3, 12, 32'h7fffffff, 15, 4095);
    send(CMD_LOAD_P, 12, 12, 32'h80000000, 15, 4095);
    send(CMD_LOAD_R, 3, 15, 32'h7fffffff, 15, 4095);
    send(CMD_LOAD_H, 4, 0, 32'h12345678, 0, 0);
    send(CMD_LOAD_H, 0, 13, 32'h12345678, 0, 0);
    send(CMD_LOAD_P, 13, 0, 32'h12345678, 0, 0);
    send(CMD_LOAD_P, 15, 15, 32'hffffffff, 15, 4095);
    send(CMD_LOAD_R, 4, 0, 32'h12345678, 0, 0);
    send(CMD_LOAD_R, 15, 0, 32'h12345678, 0, 0);
    send(CMD_COMPUTE, 0, 0, 32'h0, 4, 1);
    send(CMD_COMPUTE, 0, 0, 32'h0, 1, 2048);
    send(CMD_COMPUTE, 0, 0, 32'h0, 8, 77);
    send(CMD_LOAD_H, 0, 0, 32'h00010000, 0, 0);
    send(CMD_LOAD_R, 0, 0, 32'h80000000, 0, 0);
    send(CMD_COMPUTE, 0, 0, 32'h0, 3, 5);

    for (int n = 0; n < 228; n++) begin
      r = $urandom_range(0, 99);
      if (r < 8)
        send(CMD_COMPUTE, $urandom_range(0, 15), $urandom_range(0, 15), $urandom,
             rand_count(), $urandom_range(0, 4095));
      else if (r < 14)
        send(cmd_e'($urandom_range(0, 2)), $urandom_range(0, 15), $urandom_range(0, 15),
             $urandom, $urandom_range(0, 15), $urandom_range(0, 4095));
      else if (r < 40)
        send(CMD_LOAD_H, $urandom_range(0, MEAS_MAX-1), $urandom_range(0, STATE_DIM-1),
             rand_value(), $urandom_range(0, 15), $urandom_range(0, 4095));
      else if (r < 92)
        send(CMD_LOAD_P, $urandom_range(0, STATE_DIM-1), $urandom_range(0, STATE_DIM-1),
             rand_value(), $urandom_range(0, 15), $urandom_range(0, 4095));
      else
        send(CMD_LOAD_R, $urandom_range(0, MEAS_MAX-1), $urandom_range(0, 15),
             rand_value(), $urandom_range(0, 15), $urandom_range(0, 4095));
      if (n == 100) drain();
      else if (n < 190 && $urandom_range(0, 4) == 0) idle($urandom_range(1, 13));
    end

    drain();
    repeat (100) @(posedge clk_i);
    if (fails == 0) begin
      $display("tb_innovation_covariance_hph_top OK");
    end else begin
      $display("tb_innovation_covariance_hph_top NOT OK");
    end
    $finish;
  end

endmodule
